// ===== rtl/core/mf3_pkg.sv =====
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants, types and helper functions of the 3x3 median filter core.
// ----------------------------------------------------------------------------
package mf3_pkg;

  // Frame limits
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 512;

  // Field and register widths
  localparam int PIX_W      = 8;
  localparam int SIZE_W     = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int RESET_SIZE = 512;

  // Window geometry
  localparam int WIN_SIZE = 9;
  localparam int WIN_MID  = 4;

  // Counter widths
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CMP_A  = $clog2(MAX_DIM + 2) + 1;
  localparam int CMP_W  = (CMP_A > SIZE_W + 1) ? CMP_A : SIZE_W + 1;

  // Line store entry holds the upper and the lower line
  localparam int LS_W = 2 * PIX_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Input commands
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CMP_W-1:0] dim_t;

  typedef struct packed {
    pix_t lo;
    pix_t mid;
    pix_t hi;
  } trio_t;

  // Clamp a size register to 3..hi
  function automatic dim_t clamp_size(input logic [SIZE_W-1:0] v, input dim_t hi);
    dim_t ve;
    ve = dim_t'(v);
    if (ve < dim_t'(3)) return dim_t'(3);
    if (ve > hi) return hi;
    return ve;
  endfunction

  // Three-element sorting network
  function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
    pix_t x0, x1, x2, t;
    trio_t r;
    x0 = a;
    x1 = b;
    x2 = c;
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    if (x1 > x2) begin
      t = x1; x1 = x2; x2 = t;
    end
    if (x0 > x1) begin
      t = x0; x0 = x1; x1 = t;
    end
    r.lo  = x0;
    r.mid = x1;
    r.hi  = x2;
    return r;
  endfunction

  function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
    pix_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

// ===== rtl/core/mf3_ram.sv =====
// ----------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module mf3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/median_filter_3x3_stream_core.sv =====
// ----------------------------------------------------------------------------
// median_filter_3x3_stream_core
// Streaming 3x3 median filter over raster-order 8-bit pixels, with two line
// stores held in one RAM and a registered median network.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata: pixel_in, tuser: command
//  out_    | out | out_tvalid/tready  | tdata: pixel_out, tlast: frame_last
//  cfg_    | in  | cfg_we             | cfg_index, cfg_wdata
//
//  One pixel per clock sustained while the output is not stalled. Five
//  register stages (RAM read, window shift, three median stages) lie
//  between an input transaction and the result transaction it completes.
//  After reset a clearing pass zeroes every line store RAM entry;
//  in_tready stays low during it.
//  A stalled output stalls the whole pipeline; no transaction is lost.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mf3_pkg::PIX_W-1:0]     in_tdata,   // [7:0] pixel_in
  input  logic                          in_tuser,   // [0] command
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mf3_pkg::PIX_W-1:0]     out_tdata,  // [7:0] pixel_out
  output logic                          out_tlast,
  input  logic                          cfg_we,
  input  logic [mf3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mf3_pkg::SIZE_W-1:0]    cfg_wdata
);

  import mf3_pkg::*;

  // Configuration and frame position
  logic [SIZE_W-1:0] width_r, height_r;
  logic [COL_W-1:0]  in_col_r, in_col_nxt;
  logic [IROW_W-1:0] in_row_r, in_row_nxt;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              done_r, done_nxt;

  // Clearing pass
  logic              clr_active_r;
  logic [COL_W-1:0]  clr_addr_r;

  // Pipeline control
  logic adv, acc, eff;
  logic res_v, border, last;

  // Stage 1: RAM read data returning
  logic             s1_v_r, s1_res_r, s1_border_r, s1_last_r;
  pix_t             s1_pix_r;
  logic [COL_W-1:0] s1_addr_r;

  // Stage 2: window valid
  pix_t win_r [WIN_SIZE];
  logic s2_v_r, s2_border_r, s2_last_r;

  // Stage 3: rows sorted
  trio_t row_r [3];
  pix_t  s3_ctr_r;
  logic  s3_v_r, s3_border_r, s3_last_r;

  // Stage 4: max of lows, median of mids, min of highs
  pix_t s4_a_r, s4_b_r, s4_c_r, s4_ctr_r;
  logic s4_v_r, s4_border_r, s4_last_r;

  // Output register
  logic out_v_r, out_last_r;
  pix_t out_pix_r;

  // RAM ports
  logic             ram_we, ram_re;
  logic [COL_W-1:0] ram_waddr, ram_raddr;
  logic [LS_W-1:0]  ram_wdata, ram_rdata;
  logic [LS_W-1:0]  fwd_data_r, ls_word;
  logic             fwd_r;
  pix_t             ls_up, ls_lo;

  dim_t w_eff, h_eff, col_inc, orow_e, ocol_e;
  trio_t mid_sort, fin_sort;

  assign w_eff = clamp_size(width_r, dim_t'(MAX_WIDTH));
  assign h_eff = clamp_size(height_r, dim_t'(MAX_HEIGHT));

  // Handshake
  assign adv       = !out_v_r || out_tready;
  assign in_tready = adv && !clr_active_r;
  assign acc       = in_tvalid && in_tready;
  assign eff       = acc && (in_tuser == done_r);

  // Position bookkeeping for one effective transaction
  assign col_inc = dim_t'(in_col_r) + dim_t'(1);
  assign orow_e  = dim_t'(out_row_r);
  assign ocol_e  = dim_t'(out_col_r);

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    done_nxt    = done_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    res_v  = (dim_t'(in_row_r) >= dim_t'(2)) ||
             ((dim_t'(in_row_r) == dim_t'(1)) && (in_col_r != '0));
    border = !((orow_e >= dim_t'(1)) && (orow_e + dim_t'(1) < h_eff) &&
               (ocol_e >= dim_t'(1)) && (ocol_e + dim_t'(1) < w_eff));
    last   = (orow_e + dim_t'(1) >= h_eff) && (ocol_e + dim_t'(1) >= w_eff);
    if (eff) begin
      if (col_inc >= w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + IROW_W'(1);
        if (dim_t'(in_row_r) + dim_t'(1) >= h_eff) begin
          done_nxt = 1'b1;
        end
      end else begin
        in_col_nxt = col_inc[COL_W-1:0];
      end
      if (res_v) begin
        if (last) begin
          in_col_nxt  = '0;
          in_row_nxt  = '0;
          done_nxt    = 1'b0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end else if (ocol_e + dim_t'(1) >= w_eff) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_r + COL_W'(1);
        end
      end
    end
  end

  // Control registers, configuration and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= SIZE_W'(RESET_SIZE);
      height_r     <= SIZE_W'(RESET_SIZE);
      in_col_r     <= '0;
      in_row_r     <= '0;
      out_col_r    <= '0;
      out_row_r    <= '0;
      done_r       <= 1'b0;
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      if (clr_active_r) begin
        clr_addr_r <= clr_addr_r + COL_W'(1);
        if (clr_addr_r == COL_W'(MAX_WIDTH - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_HEIGHT: height_r <= cfg_wdata;
          default:    width_r  <= width_r;
        endcase
        in_col_r  <= '0;
        in_row_r  <= '0;
        out_col_r <= '0;
        out_row_r <= '0;
        done_r    <= 1'b0;
      end else begin
        in_col_r  <= in_col_nxt;
        in_row_r  <= in_row_nxt;
        out_col_r <= out_col_nxt;
        out_row_r <= out_row_nxt;
        done_r    <= done_nxt;
      end
    end
  end

  // Line store RAM: read per effective item, write back when it leaves stage 1.
  // The first item of a frame reads column 0 at the edge where the last item
  // of the previous frame writes it back; that word is forwarded.
  assign ls_word   = fwd_r ? fwd_data_r : ram_rdata;
  assign ls_up     = ls_word[LS_W-1:PIX_W];
  assign ls_lo     = ls_word[PIX_W-1:0];
  assign ram_re    = eff;
  assign ram_raddr = in_col_r;
  assign ram_we    = clr_active_r || (adv && s1_v_r);
  assign ram_waddr = clr_active_r ? clr_addr_r : s1_addr_r;
  assign ram_wdata = clr_active_r ? '0 : {ls_lo, s1_pix_r};

  // Forward a write that lands on the entry being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r      <= 1'b0;
      fwd_data_r <= '0;
    end else if (ram_re) begin
      fwd_r      <= ram_we && (ram_waddr == ram_raddr);
      fwd_data_r <= ram_wdata;
    end
  end

  mf3_ram #(
    .WIDTH (LS_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sort = sort3(row_r[0].mid, row_r[1].mid, row_r[2].mid);
  assign fin_sort = sort3(s4_a_r, s4_b_r, s4_c_r);

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r  <= eff;
      s2_v_r  <= s1_v_r && s1_res_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      out_v_r <= s4_v_r;
    end
  end

  // Window shift: oldest line in row 0, newest pixel in column 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_SIZE; i++) begin
        win_r[i] <= '0;
      end
    end else if (adv && s1_v_r) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]   <= win_r[r*3+1];
        win_r[r*3+1] <= win_r[r*3+2];
      end
      win_r[2] <= ls_up;
      win_r[5] <= ls_lo;
      win_r[8] <= s1_pix_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      s1_pix_r    <= (in_tuser == CMD_FLUSH) ? '0 : in_tdata;
      s1_addr_r   <= in_col_r;
      s1_res_r    <= res_v;
      s1_border_r <= border;
      s1_last_r   <= last;
      // stage 2
      s2_border_r <= s1_border_r;
      s2_last_r   <= s1_last_r;
      // stage 3: sort each window row
      for (int r = 0; r < 3; r++) begin
        row_r[r] <= sort3(win_r[r*3], win_r[r*3+1], win_r[r*3+2]);
      end
      s3_ctr_r    <= win_r[WIN_MID];
      s3_border_r <= s2_border_r;
      s3_last_r   <= s2_last_r;
      // stage 4
      s4_a_r      <= max3(row_r[0].lo, row_r[1].lo, row_r[2].lo);
      s4_b_r      <= mid_sort.mid;
      s4_c_r      <= min3(row_r[0].hi, row_r[1].hi, row_r[2].hi);
      s4_ctr_r    <= s3_ctr_r;
      s4_border_r <= s3_border_r;
      s4_last_r   <= s3_last_r;
      // output: median of the three, or the center on the border
      out_pix_r   <= s4_border_r ? s4_ctr_r : fin_sort.mid;
      out_last_r  <= s4_last_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

  // Checks
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !in_tready)
    else $error("input accepted during line store clearing pass");

  a_drain_row: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (dim_t'(in_row_r) >= h_eff))
    else $error("drain running before the last input line");

  a_stage1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !adv) |=> (s1_v_r && $stable(s1_addr_r) && $stable(ram_rdata)))
    else $error("stage 1 lost its item during a stall");

endmodule
